// ===== sv/bd_pkg.sv =====
// Shared types, constants and helper functions for the block downsampler.
// No dependencies; every other file imports this package.
package bd_pkg;

  localparam int PIX_W         = 16;
  localparam int ACC_W         = 24;
  localparam int MAX_DST_WIDTH = 1024;
  localparam int MAX_SCALE     = 16;
  localparam int COL_W         = $clog2(MAX_DST_WIDTH);
  localparam int DW_W          = 11;
  localparam int SC_W          = 5;
  localparam int SUB_W         = 4;
  localparam int DIV_W         = 9;
  localparam int CNT_W         = $clog2(ACC_W);
  localparam int CFG_DATA_W    = 11;
  localparam int CFG_IDX_W     = 2;

  // mode bits: bit 1 selects minimum, else bit 0 selects average, else centre pick
  localparam int MODE_MIN_BIT = 1;
  localparam int MODE_AVG_BIT = 0;

  localparam logic [1:0] MODE_CENTRE    = 2'd0;
  localparam logic [1:0] MODE_AVERAGE   = 2'd1;
  localparam logic [1:0] MODE_MINIMUM   = 2'd2;
  localparam logic [1:0] MODE_MIN_ALIAS = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 2'd0,
    CFG_X_SCALE   = 2'd1,
    CFG_Y_SCALE   = 2'd2,
    CFG_DST_WIDTH = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    logic [PIX_W-1:0] src_pixel;
    logic             frame_start;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             row_end;
  } out_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [SC_W-1:0] xs;
    logic [SC_W-1:0] ys;
    logic [DW_W-1:0] dw;
  } cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0] rp;
    logic [COL_W-1:0] col;
    logic             last_x;
    logic             last_y;
    logic             last_col;
    logic             sub_y0;
    logic             pick_y;
    logic [DIV_W-1:0] divisor;
  } s1_t;

  function automatic logic [SC_W-1:0] clamp_scale(input logic [SC_W-1:0] v);
    logic [SC_W-1:0] r;
    r = v;
    if (v == '0) r = SC_W'(1);
    else if (v > SC_W'(MAX_SCALE)) r = SC_W'(MAX_SCALE);
    return r;
  endfunction

  function automatic logic [DW_W-1:0] clamp_width(input logic [DW_W-1:0] v);
    logic [DW_W-1:0] r;
    r = v;
    if (v == '0) r = DW_W'(1);
    else if (v > DW_W'(MAX_DST_WIDTH)) r = DW_W'(MAX_DST_WIDTH);
    return r;
  endfunction

  function automatic logic [ACC_W-1:0] combine(input logic [1:0] mode,
                                               input logic [ACC_W-1:0] acc,
                                               input logic [ACC_W-1:0] v,
                                               input logic pick);
    logic [ACC_W-1:0] r;
    if (mode[MODE_MIN_BIT]) r = (v < acc) ? v : acc;
    else if (mode[MODE_AVG_BIT]) r = acc + v;
    else r = pick ? v : acc;
    return r;
  endfunction

endpackage

// ===== sv/bd_colmem.sv =====
// Per-column line memory of partial block results.
// One write port, one read port with registered read data. Uses bd_pkg.
module bd_colmem (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [bd_pkg::COL_W-1:0] rd_addr,
  output logic [bd_pkg::ACC_W-1:0] rd_data,
  input  logic                     wr_en,
  input  logic [bd_pkg::COL_W-1:0] wr_addr,
  input  logic [bd_pkg::ACC_W-1:0] wr_data
);
  import bd_pkg::*;

  logic [ACC_W-1:0] mem [MAX_DST_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/bd_div.sv =====
// Restoring divider, one quotient bit per cycle, for the block average.
// Holds the result until taken. Uses bd_pkg.
module bd_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [bd_pkg::ACC_W-1:0] dividend,
  input  logic [bd_pkg::DIV_W-1:0] divisor,
  input  logic                     take,
  output logic                     busy,
  output logic                     done,
  output logic [bd_pkg::PIX_W-1:0] quotient
);
  import bd_pkg::*;

  div_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [ACC_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_W:0]   rem_sh, diff;
  logic             ge;

  assign rem_sh = {rem_r, quo_r[ACC_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DIV_IDLE: if (start) state_nxt = DIV_RUN;
      DIV_RUN:  if (cnt_r == CNT_W'(ACC_W - 1)) state_nxt = DIV_DONE;
      DIV_DONE: if (take) state_nxt = DIV_IDLE;
      default:  state_nxt = DIV_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    unique case (state_r)
      DIV_IDLE: begin
        cnt_nxt = '0;
        rem_nxt = '0;
        quo_nxt = dividend;
        dvs_nxt = divisor;
      end
      DIV_RUN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        rem_nxt = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        quo_nxt = {quo_r[ACC_W-2:0], ge};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = state_r != DIV_IDLE;
  assign done     = state_r == DIV_DONE;
  assign quotient = quo_r[PIX_W-1:0];

endmodule

// ===== sv/bd_pos.sv =====
// Position counters and horizontal partial of the current block row.
// Produces the per-transaction column update info. Uses bd_pkg.
module bd_pos (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  bd_pkg::in_t   in_data,
  input  bd_pkg::cfg_t  cfg,
  output bd_pkg::s1_t   info
);
  import bd_pkg::*;

  logic [ACC_W-1:0] row_partial_r, row_partial_nxt;
  logic [SUB_W-1:0] sub_x_r, sub_x_nxt;
  logic [SUB_W-1:0] sub_y_r, sub_y_nxt;
  logic [COL_W-1:0] dst_col_r, dst_col_nxt;
  logic [SUB_W-1:0] sx, sy;
  logic [COL_W-1:0] sc;
  logic             last_x, last_y, last_col, pick_x;
  logic [ACC_W-1:0] pix;
  logic [2*SC_W-1:0] area;

  assign sx  = in_data.frame_start ? '0 : sub_x_r;
  assign sy  = in_data.frame_start ? '0 : sub_y_r;
  assign sc  = in_data.frame_start ? '0 : dst_col_r;
  assign pix = ACC_W'(in_data.src_pixel);

  assign last_x   = {1'b0, sx} >= (cfg.xs - SC_W'(1));
  assign last_y   = {1'b0, sy} >= (cfg.ys - SC_W'(1));
  assign last_col = {1'b0, sc} >= (cfg.dw - DW_W'(1));
  assign pick_x   = {1'b0, sx} == (cfg.xs >> 1);
  assign area     = cfg.xs * cfg.ys;

  always_comb begin
    row_partial_nxt = (sx == '0) ? pix : combine(cfg.mode, row_partial_r, pix, pick_x);
    sub_x_nxt   = sx + SUB_W'(1);
    sub_y_nxt   = sy;
    dst_col_nxt = sc;
    if (last_x) begin
      sub_x_nxt = '0;
      if (last_col) begin
        dst_col_nxt = '0;
        sub_y_nxt   = last_y ? '0 : sy + SUB_W'(1);
      end else begin
        dst_col_nxt = sc + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_partial_r <= '0;
      sub_x_r       <= '0;
      sub_y_r       <= '0;
      dst_col_r     <= '0;
    end else if (accept) begin
      row_partial_r <= row_partial_nxt;
      sub_x_r       <= sub_x_nxt;
      sub_y_r       <= sub_y_nxt;
      dst_col_r     <= dst_col_nxt;
    end
  end

  assign info.rp       = row_partial_nxt;
  assign info.col      = sc;
  assign info.last_x   = last_x;
  assign info.last_y   = last_y;
  assign info.last_col = last_col;
  assign info.sub_y0   = sy == '0;
  assign info.pick_y   = {1'b0, sy} == (cfg.ys >> 1);
  assign info.divisor  = area[DIV_W-1:0];

endmodule

// ===== sv/block_downsampler_core.sv =====
// Block downsampler top: config registers, column read-modify-write stage, output register.
// Path: an input transaction is registered in the column stage, then in the output register
// in centre and minimum modes; average results pass 24 divider steps and a done state first.
// Throughput: one pixel per cycle, except that a block result waits in the column stage while
// the output register is full (centre, minimum) or the divider is busy (average).
// Reset: synchronous active-low; counters and partials clear, line memory is left as is.
module block_downsampler_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bd_pkg::in_t                 in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bd_pkg::out_t                out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bd_pkg::*;

  logic [1:0]      mode_r;
  logic [SC_W-1:0] x_scale_r, y_scale_r;
  logic [DW_W-1:0] dst_width_r;
  cfg_t            cfg;

  s1_t              pos_info, s1_r;
  logic             s1_v_r;
  logic             in_acc, s1_adv, s1_res, avg;
  logic [ACC_W-1:0] rd_data, memval, colval;

  logic             fwd_v_r;
  logic [COL_W-1:0] fwd_addr_r;
  logic [ACC_W-1:0] fwd_data_r;

  logic             div_start, div_busy, div_done, div_take;
  logic [PIX_W-1:0] div_q;
  logic             pend_row_end_r;

  logic             out_v_r, out_free;
  out_t             out_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_AVERAGE;
      x_scale_r   <= SC_W'(2);
      y_scale_r   <= SC_W'(2);
      dst_width_r <= DW_W'(MAX_DST_WIDTH);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:      mode_r      <= cfg_data[1:0];
        CFG_X_SCALE:   x_scale_r   <= cfg_data[SC_W-1:0];
        CFG_Y_SCALE:   y_scale_r   <= cfg_data[SC_W-1:0];
        CFG_DST_WIDTH: dst_width_r <= cfg_data[DW_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.mode = mode_r;
  assign cfg.xs   = clamp_scale(x_scale_r);
  assign cfg.ys   = clamp_scale(y_scale_r);
  assign cfg.dw   = clamp_width(dst_width_r);
  assign avg      = !mode_r[MODE_MIN_BIT] && mode_r[MODE_AVG_BIT];

  assign in_acc = in_valid && in_ready;

  bd_pos u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_acc),
    .in_data (in_data),
    .cfg     (cfg),
    .info    (pos_info)
  );

  bd_colmem u_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (pos_info.col),
    .rd_data (rd_data),
    .wr_en   (s1_adv && s1_r.last_x),
    .wr_addr (s1_r.col),
    .wr_data (colval)
  );

  // write in the read cycle is not seen by the memory read
  assign memval = (fwd_v_r && fwd_addr_r == s1_r.col) ? fwd_data_r : rd_data;
  assign colval = s1_r.sub_y0 ? s1_r.rp : combine(mode_r, memval, s1_r.rp, s1_r.pick_y);

  assign out_free = !out_v_r || out_ready;
  assign s1_res   = s1_r.last_x && s1_r.last_y;
  assign s1_adv   = s1_v_r && (!s1_res || (!div_busy && (avg || out_free)));
  assign in_ready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      if (in_ready) s1_v_r <= in_valid;
      if (s1_adv && s1_r.last_x) fwd_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_r <= pos_info;
    if (s1_adv && s1_r.last_x) begin
      fwd_addr_r <= s1_r.col;
      fwd_data_r <= colval;
    end
    if (div_start) pend_row_end_r <= s1_r.last_col;
  end

  assign div_start = s1_adv && s1_res && avg;
  assign div_take  = div_done && out_free;

  bd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (colval),
    .divisor  (s1_r.divisor),
    .take     (div_take),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (div_take || (s1_adv && s1_res && !avg)) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_take) begin
      out_r.out_pixel <= div_q;
      out_r.row_end   <= pend_row_end_r;
    end else if (s1_adv && s1_res && !avg) begin
      out_r.out_pixel <= colval[PIX_W-1:0];
      out_r.row_end   <= s1_r.last_col;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== tb/tb_block_downsampler_core.sv =====
// Self-checking testbench for block_downsampler_core: directed and random pixel streams,
// with a transaction-level predictor of the block decimation and a result checker.
// Depends on bd_pkg (ports, register indexes, mode codes) and the block itself.
module tb_block_downsampler_core;
  import bd_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 900;
  localparam int unsigned QUIET_ITEMS   = 150;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 250;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned MAX_PRINTS    = 100;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  block_downsampler_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register mirror
  logic [1:0]  rg_mode;
  logic [4:0]  rg_xs;
  logic [4:0]  rg_ys;
  logic [10:0] rg_dw;

  // block state mirror
  logic [ACC_W-1:0] line_acc [MAX_DST_WIDTH];
  logic [ACC_W-1:0] run_acc;
  int unsigned      px_x;
  int unsigned      px_y;
  int unsigned      ocol;

  out_t        expected_pixels[$];
  int unsigned err_count;
  bit          src_gaps;
  bit          sink_gaps;
  bit          hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (err_count < MAX_PRINTS) $display("mismatch: %s", what);
    err_count++;
  endtask

  function automatic int unsigned eff_scale(input logic [4:0] v);
    if (v == 5'd0) return 1;
    if (v > 5'(MAX_SCALE)) return MAX_SCALE;
    return v;
  endfunction

  function automatic int unsigned eff_width(input logic [10:0] v);
    if (v == 11'd0) return 1;
    if (v > 11'(MAX_DST_WIDTH)) return MAX_DST_WIDTH;
    return v;
  endfunction

  function automatic logic [ACC_W-1:0] merge_acc(input logic [ACC_W-1:0] acc,
                                                 input logic [ACC_W-1:0] v,
                                                 input bit pick);
    if (rg_mode[MODE_MIN_BIT]) return (v < acc) ? v : acc;
    if (rg_mode[MODE_AVG_BIT]) return acc + v;
    return pick ? v : acc;
  endfunction

  task automatic predict_pixel(input in_t px);
    int unsigned      xs;
    int unsigned      ys;
    int unsigned      dw;
    bit               lx;
    bit               ly;
    bit               lc;
    logic [ACC_W-1:0] cv;
    out_t             r;
    xs = eff_scale(rg_xs);
    ys = eff_scale(rg_ys);
    dw = eff_width(rg_dw);
    if (px.frame_start) begin
      px_x = 0;
      px_y = 0;
      ocol = 0;
    end
    lx = px_x >= xs - 1;
    ly = px_y >= ys - 1;
    lc = ocol >= dw - 1;
    if (px_x == 0) run_acc = ACC_W'(px.src_pixel);
    else run_acc = merge_acc(run_acc, ACC_W'(px.src_pixel), px_x == xs / 2);
    if (lx) begin
      if (px_y == 0) cv = run_acc;
      else cv = merge_acc(line_acc[ocol], run_acc, px_y == ys / 2);
      line_acc[ocol] = cv;
      if (ly) begin
        if (rg_mode == MODE_AVERAGE) r.out_pixel = PIX_W'(cv / (xs * ys));
        else r.out_pixel = cv[PIX_W-1:0];
        r.row_end = lc;
        expected_pixels.push_back(r);
      end
      px_x = 0;
      if (lc) begin
        ocol = 0;
        px_y = ly ? 0 : ((px_y + 1) & 15);
      end else begin
        ocol = (ocol + 1) & 1023;
      end
    end else begin
      px_x = (px_x + 1) & 15;
    end
  endtask

  // result checker
  initial begin
    out_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected result pixel %h row_end %b",
                                    out_data.out_pixel, out_data.row_end));
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.out_pixel !== want.out_pixel)
            report_mismatch($sformatf("out_pixel got %h exp %h",
                                      out_data.out_pixel, want.out_pixel));
          if (out_data.row_end !== want.row_end)
            report_mismatch($sformatf("row_end got %b exp %b",
                                      out_data.row_end, want.row_end));
        end
      end
    end
  end

  // result receiver
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    int unsigned stall_count;
    stall_count = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_count = 0;
      else
        stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("** block_downsampler_core: FAILED **");
        $finish;
      end
    end
  end

  // all stimulus tasks start and end just after a falling edge
  task automatic send_pixel(input logic [15:0] pix, input logic fs);
    in_t item;
    item.src_pixel   = pix;
    item.frame_start = fs;
    in_data  = item;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(item);
    @(negedge clk);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [10:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MODE:      rg_mode = val[1:0];
      CFG_X_SCALE:   rg_xs   = val[4:0];
      CFG_Y_SCALE:   rg_ys   = val[4:0];
      CFG_DST_WIDTH: rg_dw   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_format(input logic [1:0] md, input logic [4:0] x, input logic [4:0] y,
                            input logic [10:0] w);
    drain();
    write_reg(CFG_MODE, {9'($urandom), md});
    write_reg(CFG_X_SCALE, {6'($urandom), x});
    write_reg(CFG_Y_SCALE, {6'($urandom), y});
    write_reg(CFG_DST_WIDTH, w);
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [4:0] pick_scale();
    int unsigned r;
    r = $urandom_range(0, 11);
    if (r == 0) return 5'd0;
    if (r == 1) return 5'($urandom_range(17, 31));
    if (r == 2) return 5'd16;
    return 5'($urandom_range(1, 4));
  endfunction

  function automatic logic [10:0] pick_width();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 11'd0;
    if (r == 1) return 11'($urandom_range(7, 12));
    return 11'($urandom_range(1, 6));
  endfunction

  // mode, scales as after reset; only the width is narrowed
  task automatic test_reset_defaults();
    write_reg(CFG_DST_WIDTH, 11'd1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'h0000, 1'b0);
    drain();
  endtask

  // one full-width row writes every line entry; alias mode, zero scale, oversize width
  task automatic test_line_fill();
    int unsigned i;
    set_format(MODE_MIN_ALIAS, 5'd0, 5'd1, 11'd2047);
    for (i = 0; i < MAX_DST_WIDTH + 4; i++) send_pixel(rand_pixel(), i == 0);
    drain();
  endtask

  task automatic test_directed_modes();
    set_format(MODE_MINIMUM, 5'd2, 5'd1, 11'd2);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'hFFFE, 1'b0);
    send_pixel(16'h8000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    set_format(MODE_AVERAGE, 5'd2, 5'd2, 11'd1);
    send_pixel(16'hFFFF, 1'b1);
    repeat (3) send_pixel(16'hFFFF, 1'b0);
    set_format(MODE_CENTRE, 5'd3, 5'd1, 11'd1);
    send_pixel(16'h1111, 1'b1);
    send_pixel(16'h2222, 1'b0);
    send_pixel(16'h3333, 1'b0);
    set_format(MODE_CENTRE, 5'd2, 5'd2, 11'd1);
    send_pixel(16'h0001, 1'b1);
    send_pixel(16'h0002, 1'b0);
    send_pixel(16'h0003, 1'b0);
    send_pixel(16'h0004, 1'b0);
    drain();
  endtask

  // frame start in the middle of a block restarts it
  task automatic test_frame_restart();
    set_format(MODE_AVERAGE, 5'd2, 5'd2, 11'd1);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0004, 1'b1);
    send_pixel(16'h0008, 1'b0);
    send_pixel(16'h000C, 1'b0);
    send_pixel(16'h0010, 1'b0);
    drain();
  endtask

  task automatic test_backpressure();
    int unsigned i;
    set_format(MODE_CENTRE, 5'd1, 5'd1, 11'd8);
    src_gaps = 1'b0;
    hold_req = 1'b1;
    for (i = 0; i < 100; i++) send_pixel(rand_pixel(), i == 0);
    drain();
    src_gaps = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned frames;
    int unsigned f;
    int unsigned i;
    int unsigned len;
    int unsigned area;
    logic [4:0]  x;
    logic [4:0]  y;
    logic [10:0] w;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      x = pick_scale();
      y = pick_scale();
      w = pick_width();
      area = eff_scale(x) * eff_scale(y) * eff_width(w);
      if (area > 320) begin
        w = 11'd1;
        area = eff_scale(x) * eff_scale(y);
      end
      set_format(2'($urandom_range(0, 3)), x, y, w);
      if (sent + QUIET_ITEMS < RANDOM_ITEMS) begin
        src_gaps  = $urandom_range(0, 3) != 0;
        sink_gaps = $urandom_range(0, 3) != 0;
      end
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        len = area * $urandom_range(1, 2);
        if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len);
        for (i = 0; i < len; i++) begin
          if (sent + QUIET_ITEMS >= RANDOM_ITEMS) begin
            src_gaps  = 1'b0;
            sink_gaps = 1'b0;
          end
          send_pixel(rand_pixel(), (i == 0) || ($urandom_range(0, 63) == 0));
          sent++;
        end
      end
      // register change with a frame still open
      if ($urandom_range(0, 2) == 0) begin
        drain();
        write_reg(cfg_idx_t'($urandom_range(0, 3)), 11'($urandom));
        len = $urandom_range(5, 40);
        for (i = 0; i < len; i++) send_pixel(rand_pixel(), 1'b0);
        sent += len;
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MODE;
    cfg_data  = '0;
    err_count = 0;
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    hold_req  = 1'b0;
    rg_mode   = MODE_AVERAGE;
    rg_xs     = 5'd2;
    rg_ys     = 5'd2;
    rg_dw     = 11'd1024;
    run_acc   = '0;
    px_x      = 0;
    px_y      = 0;
    ocol      = 0;
    foreach (line_acc[i]) line_acc[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_line_fill();
    test_directed_modes();
    test_frame_restart();
    test_backpressure();
    test_random_frames();
    drain();

    if (err_count == 0) begin
      $display("** block_downsampler_core: PASSED **");
    end else begin
      $display("** block_downsampler_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bd_pkg.sv
sv/bd_colmem.sv
sv/bd_div.sv
sv/bd_pos.sv
sv/block_downsampler_core.sv
tb/tb_block_downsampler_core.sv
